// ===== rtl/sdps_pkg.sv =====
// ----------------------------------------------------------------------------
// sdps_pkg
// Shared widths, register indexes and payload types of the sphere shader.
// ----------------------------------------------------------------------------
package sdps_pkg;

  localparam int PIX_W   = 12;
  localparam int CTR_W   = 12;
  localparam int RAD_W   = 10;
  localparam int RGB_W   = 24;
  localparam int LGT_W   = 16;
  localparam int CH_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z  = 3'd6;

  // depth square root: radicand (r*r - d*d) << 16
  localparam int ZRAD_W = 36;
  localparam int ZN     = ZRAD_W / 2;
  // light vector length square root
  localparam int LRAD_W = 50;
  localparam int LN     = LRAD_W / 2;
  localparam int DEN_W  = RAD_W + LN;
  localparam int DOT_W  = 44;

  typedef struct packed {
    logic              hit;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic signed [16:0] lx0;
    logic signed [16:0] ly0;
  } zpay_t;

  typedef struct packed {
    logic              hit;
    logic              pos;
    logic [DOT_W-1:0]  dmag;
  } lpay_t;

  typedef struct packed {
    logic hit;
    logic ok;
  } dpay_t;

endpackage

// ===== rtl/sdps_pix_if.sv =====
// ----------------------------------------------------------------------------
// sdps_pix_if
// Pixel coordinate channel, valid/ready.
// ----------------------------------------------------------------------------
interface sdps_pix_if;
  logic                       valid;
  logic                       ready;
  logic [sdps_pkg::PIX_W-1:0] pixel_x;
  logic [sdps_pkg::PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/sdps_res_if.sv =====
// ----------------------------------------------------------------------------
// sdps_res_if
// Shaded pixel result channel, valid/ready.
// ----------------------------------------------------------------------------
interface sdps_res_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [sdps_pkg::CH_W-1:0] red;
  logic [sdps_pkg::CH_W-1:0] green;
  logic [sdps_pkg::CH_W-1:0] blue;

  modport source (output valid, output hit, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input hit, input red, input green, input blue,
                output ready);
endinterface

// ===== rtl/sdps_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sdps_sqrt_cell
// One digit step of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module sdps_sqrt_cell #(
  parameter int RW = 36,
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              ld,
  input  logic [RW-1:0]     rad_i,
  input  logic [RW/2+1:0]   rem_i,
  input  logic [RW/2-1:0]   root_i,
  input  logic [PW-1:0]     pay_i,
  output logic [RW-1:0]     rad_r,
  output logic [RW/2+1:0]   rem_r,
  output logic [RW/2-1:0]   root_r,
  output logic [PW-1:0]     pay_r
);

  logic [RW/2+1:0] remsh;
  logic [RW/2+1:0] trial;
  logic            ge;
  logic [RW-1:0]   rad_nxt;
  logic [RW/2+1:0] rem_nxt;
  logic [RW/2-1:0] root_nxt;

  always_comb begin
    remsh    = {rem_i[RW/2-1:0], rad_i[RW-1:RW-2]};
    trial    = {root_i, 2'b01};
    ge       = (remsh >= trial);
    rem_nxt  = ge ? (remsh - trial) : remsh;
    root_nxt = {root_i[RW/2-2:0], ge};
    rad_nxt  = {rad_i[RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= pay_i;
    end
  end

endmodule

// ===== rtl/sdps_div_cell.sv =====
// ----------------------------------------------------------------------------
// sdps_div_cell
// One quotient bit of a restoring divider, registered.
// ----------------------------------------------------------------------------
module sdps_div_cell #(
  parameter int NW = 52,
  parameter int DW = 35,
  parameter int QW = 19,
  parameter int SH = 0,
  parameter int PW = 2
) (
  input  logic          clk,
  input  logic          ld,
  input  logic [NW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] q_i,
  input  logic [PW-1:0] pay_i,
  output logic [NW-1:0] rem_r,
  output logic [DW-1:0] den_r,
  output logic [QW-1:0] q_r,
  output logic [PW-1:0] pay_r
);

  localparam int CW = NW + DW;

  logic [CW-1:0] dsh;
  logic [CW-1:0] remx;
  logic          ge;
  logic [NW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;

  always_comb begin
    dsh     = CW'(den_i) << SH;
    remx    = CW'(rem_i);
    ge      = (remx >= dsh);
    rem_nxt = ge ? NW'(remx - dsh) : rem_i;
    q_nxt   = ge ? (q_i | (QW'(1) << SH)) : q_i;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
      pay_r <= pay_i;
    end
  end

endmodule

// ===== rtl/sphere_diffuse_pixel_shader_core.sv =====
// ----------------------------------------------------------------------------
// sphere_diffuse_pixel_shader_core
// Lambert shading of one sphere, one pixel per clock through a cell chain when not stalled.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid/ready      pixel_x, pixel_y
//  out_ch    out   valid/ready      hit, red, green, blue
//  cfg_*     in    cfg_we only      cfg_index, cfg_data
//
//  one pixel per clock while the output is not stalled; the latency is set by
//  the depth and length square root chains and the divider
//  each stage holds while the output is stalled, empty stages keep filling
//  so input is taken when the first stage is empty or the chain moves
//  synchronous active-low reset clears stage valids and config registers
// ----------------------------------------------------------------------------
module sphere_diffuse_pixel_shader_core #(
  parameter int CANVAS_WIDTH  = 800,
  parameter int CANVAS_HEIGHT = 600,
  parameter int FRAC_BITS     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sdps_pix_if.sink                         in_ch,
  sdps_res_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [sdps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ZN     = sdps_pkg::ZN;
  localparam int LN     = sdps_pkg::LN;
  localparam int ZRW    = sdps_pkg::ZRAD_W;
  localparam int LRW    = sdps_pkg::LRAD_W;
  localparam int DENW   = sdps_pkg::DEN_W;
  localparam int NUMW   = sdps_pkg::DOT_W + FRAC_BITS - 8;
  localparam int QW     = FRAC_BITS + 3;
  localparam int DC     = QW;
  localparam int ZPW    = $bits(sdps_pkg::zpay_t);
  localparam int LPW    = $bits(sdps_pkg::lpay_t);
  localparam int DPW    = $bits(sdps_pkg::dpay_t);
  localparam int ST_S1  = 0;
  localparam int ST_S2  = 1;
  localparam int ST_S3  = 2;
  localparam int ST_Z0  = 3;
  localparam int ST_L   = ST_Z0 + ZN;
  localparam int ST_M   = ST_L + 1;
  localparam int ST_N   = ST_L + 2;
  localparam int ST_Q0  = ST_L + 3;
  localparam int ST_D   = ST_Q0 + LN;
  localparam int ST_V0  = ST_D + 1;
  localparam int ST_C   = ST_V0 + DC;
  localparam int NST    = ST_C + 1;

  // ---------------- configuration ----------------
  logic signed [11:0] cx_r, cy_r;
  logic [9:0]         rad_r;
  logic [23:0]        rgb_r;
  logic signed [15:0] lxp_r, lyp_r, lzp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rad_r <= '0;
      rgb_r <= '0;
      lxp_r <= '0;
      lyp_r <= '0;
      lzp_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdps_pkg::REG_CENTER_X: cx_r  <= cfg_data[11:0];
        sdps_pkg::REG_CENTER_Y: cy_r  <= cfg_data[11:0];
        sdps_pkg::REG_RADIUS:   rad_r <= cfg_data[9:0];
        sdps_pkg::REG_COLOR:    rgb_r <= cfg_data[23:0];
        sdps_pkg::REG_LIGHT_X:  lxp_r <= cfg_data[15:0];
        sdps_pkg::REG_LIGHT_Y:  lyp_r <= cfg_data[15:0];
        sdps_pkg::REG_LIGHT_Z:  lzp_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- chain control ----------------
  // a stage loads when the chain moves or when it is empty
  logic [NST-1:0] v_r, v_nxt, load;
  logic           en;

  always_comb begin
    en = !v_r[NST-1] || out_ch.ready;
    for (int i = 0; i < NST; i++) begin
      load[i] = en || !v_r[i];
    end
    v_nxt[0] = load[0] ? in_ch.valid : (v_r[0] && !load[1]);
    for (int i = 1; i < NST - 1; i++) begin
      v_nxt[i] = load[i] ? v_r[i-1] : (v_r[i] && !load[i+1]);
    end
    v_nxt[NST-1] = load[NST-1] ? v_r[NST-2] : v_r[NST-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = load[ST_S1];
  assign out_ch.valid = v_r[NST-1];

  // ---------------- S1: offsets ----------------
  logic signed [13:0] dx1_r, dy1_r;
  logic signed [16:0] lx01_r, ly01_r;
  logic               onc1_r;

  always_ff @(posedge clk) begin
    if (load[ST_S1]) begin
      dx1_r  <= $signed({2'b00, in_ch.pixel_x}) - $signed({{2{cx_r[11]}}, cx_r});
      dy1_r  <= $signed({2'b00, in_ch.pixel_y}) - $signed({{2{cy_r[11]}}, cy_r});
      lx01_r <= $signed({lxp_r[15], lxp_r}) - $signed({5'b0, in_ch.pixel_x});
      ly01_r <= $signed({lyp_r[15], lyp_r}) - $signed({5'b0, in_ch.pixel_y});
      onc1_r <= ({1'b0, in_ch.pixel_x} < 13'(CANVAS_WIDTH)) &&
                ({1'b0, in_ch.pixel_y} < 13'(CANVAS_HEIGHT));
    end
  end

  // ---------------- S2: squares ----------------
  logic signed [27:0] dxx, dyy;
  logic [25:0]        dx2_r, dy2_r;
  logic [19:0]        r2_r;
  logic signed [13:0] dx2c_r, dy2c_r;
  logic signed [16:0] lx02_r, ly02_r;
  logic               onc2_r;

  assign dxx = dx1_r * dx1_r;
  assign dyy = dy1_r * dy1_r;

  always_ff @(posedge clk) begin
    if (load[ST_S2]) begin
      dx2_r  <= dxx[25:0];
      dy2_r  <= dyy[25:0];
      r2_r   <= rad_r * rad_r;
      dx2c_r <= dx1_r;
      dy2c_r <= dy1_r;
      lx02_r <= lx01_r;
      ly02_r <= ly01_r;
      onc2_r <= onc1_r;
    end
  end

  // ---------------- S3: disc test ----------------
  logic [26:0]     d2;
  logic            hit3;
  sdps_pkg::zpay_t zp3_r;
  logic [19:0]     zin3_r;

  assign d2   = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign hit3 = onc2_r && (d2 <= {7'b0, r2_r});

  always_ff @(posedge clk) begin
    if (load[ST_S3]) begin
      zp3_r.hit <= hit3;
      zp3_r.dx  <= hit3 ? dx2c_r[10:0] : '0;
      zp3_r.dy  <= hit3 ? dy2c_r[10:0] : '0;
      zp3_r.lx0 <= lx02_r;
      zp3_r.ly0 <= ly02_r;
      zin3_r    <= hit3 ? (r2_r - d2[19:0]) : '0;
    end
  end

  // ---------------- depth square root chain ----------------
  logic [ZRW-1:0]   zrad  [ZN+1];
  logic [ZRW/2+1:0] zrem  [ZN+1];
  logic [ZRW/2-1:0] zroot [ZN+1];
  logic [ZPW-1:0]   zpay  [ZN+1];

  assign zrad[0]  = {zin3_r, 16'b0};
  assign zrem[0]  = '0;
  assign zroot[0] = '0;
  assign zpay[0]  = zp3_r;

  for (genvar k = 0; k < ZN; k++) begin : g_zsq
    sdps_sqrt_cell #(.RW(ZRW), .PW(ZPW)) u_cell (
      .clk    (clk),
      .ld     (load[ST_Z0+k]),
      .rad_i  (zrad[k]),
      .rem_i  (zrem[k]),
      .root_i (zroot[k]),
      .pay_i  (zpay[k]),
      .rad_r  (zrad[k+1]),
      .rem_r  (zrem[k+1]),
      .root_r (zroot[k+1]),
      .pay_r  (zpay[k+1])
    );
  end

  // ---------------- L: light vector ----------------
  sdps_pkg::zpay_t    zpl;
  logic signed [24:0] lxl_r, lyl_r, lzl_r;
  logic [17:0]        zql_r;
  sdps_pkg::zpay_t    zpl_r;

  assign zpl = zpay[ZN];

  always_ff @(posedge clk) begin
    if (load[ST_L]) begin
      lxl_r <= {zpl.lx0, 8'b0};
      lyl_r <= {zpl.ly0, 8'b0};
      lzl_r <= $signed({lzp_r[15], lzp_r, 8'b0}) - $signed({7'b0, zroot[ZN]});
      zql_r <= zroot[ZN];
      zpl_r <= zpl;
    end
  end

  // ---------------- M: products ----------------
  logic signed [49:0] sqx, sqy, sqz;
  logic [47:0]        sqx_r, sqy_r, sqz_r;
  logic signed [27:0] pxd_r, pyd_r;
  logic signed [43:0] pzd_r;
  logic               hitm_r;

  assign sqx = lxl_r * lxl_r;
  assign sqy = lyl_r * lyl_r;
  assign sqz = lzl_r * lzl_r;

  always_ff @(posedge clk) begin
    if (load[ST_M]) begin
      sqx_r  <= sqx[47:0];
      sqy_r  <= sqy[47:0];
      sqz_r  <= sqz[47:0];
      pxd_r  <= zpl_r.dx * zpl_r.lx0;
      pyd_r  <= zpl_r.dy * zpl_r.ly0;
      pzd_r  <= $signed({1'b0, zql_r}) * lzl_r;
      hitm_r <= zpl_r.hit;
    end
  end

  // ---------------- N: length squared and dot ----------------
  logic signed [28:0] pxy;
  logic signed [44:0] dot;
  logic [LRW-1:0]     len2_r;
  sdps_pkg::lpay_t    lpn_r;

  assign pxy = 29'(pxd_r) + 29'(pyd_r);
  assign dot = $signed({pxy, 16'b0}) + 45'(pzd_r);

  always_ff @(posedge clk) begin
    if (load[ST_N]) begin
      len2_r     <= 50'(sqx_r) + 50'(sqy_r) + 50'(sqz_r);
      lpn_r.hit  <= hitm_r;
      lpn_r.pos  <= (dot > 45'sd0);
      lpn_r.dmag <= dot[43:0];
    end
  end

  // ---------------- length square root chain ----------------
  logic [LRW-1:0]   lrad  [LN+1];
  logic [LRW/2+1:0] lrem  [LN+1];
  logic [LRW/2-1:0] lroot [LN+1];
  logic [LPW-1:0]   lpay  [LN+1];

  assign lrad[0]  = len2_r;
  assign lrem[0]  = '0;
  assign lroot[0] = '0;
  assign lpay[0]  = lpn_r;

  for (genvar k = 0; k < LN; k++) begin : g_lsq
    sdps_sqrt_cell #(.RW(LRW), .PW(LPW)) u_cell (
      .clk    (clk),
      .ld     (load[ST_Q0+k]),
      .rad_i  (lrad[k]),
      .rem_i  (lrem[k]),
      .root_i (lroot[k]),
      .pay_i  (lpay[k]),
      .rad_r  (lrad[k+1]),
      .rem_r  (lrem[k+1]),
      .root_r (lroot[k+1]),
      .pay_r  (lpay[k+1])
    );
  end

  // ---------------- D: divider operands ----------------
  sdps_pkg::lpay_t lpd;
  logic [DENW-1:0] den_r;
  logic [NUMW-1:0] num_r;
  sdps_pkg::dpay_t dpd_r;

  assign lpd = lpay[LN];

  always_ff @(posedge clk) begin
    if (load[ST_D]) begin
      den_r     <= rad_r * lroot[LN];
      num_r     <= NUMW'(lpd.dmag) << (FRAC_BITS - 8);
      dpd_r.hit <= lpd.hit;
      dpd_r.ok  <= lpd.hit && lpd.pos && (lroot[LN] != '0) && (rad_r != '0);
    end
  end

  // ---------------- divider chain, msb first ----------------
  logic [NUMW-1:0] vrem [DC+1];
  logic [DENW-1:0] vden [DC+1];
  logic [QW-1:0]   vq   [DC+1];
  logic [DPW-1:0]  vpay [DC+1];

  assign vrem[0] = num_r;
  assign vden[0] = den_r;
  assign vq[0]   = '0;
  assign vpay[0] = dpd_r;

  for (genvar k = 0; k < DC; k++) begin : g_div
    sdps_div_cell #(
      .NW (NUMW),
      .DW (DENW),
      .QW (QW),
      .SH (DC - 1 - k),
      .PW (DPW)
    ) u_cell (
      .clk   (clk),
      .ld    (load[ST_V0+k]),
      .rem_i (vrem[k]),
      .den_i (vden[k]),
      .q_i   (vq[k]),
      .pay_i (vpay[k]),
      .rem_r (vrem[k+1]),
      .den_r (vden[k+1]),
      .q_r   (vq[k+1]),
      .pay_r (vpay[k+1])
    );
  end

  // ---------------- C: clamp and color ----------------
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  sdps_pkg::dpay_t   dpc;
  logic [FRAC_BITS:0] inten;
  logic [FRAC_BITS+8:0] pr, pg, pb;
  logic               hit_r;
  logic [7:0]         red_r, green_r, blue_r;

  always_comb begin
    dpc = vpay[DC];
    if (!dpc.ok) begin
      inten = '0;
    end else if (vq[DC] > ONE_Q) begin
      inten = ONE_Q[FRAC_BITS:0];
    end else begin
      inten = vq[DC][FRAC_BITS:0];
    end
    pr = rgb_r[23:16] * inten;
    pg = rgb_r[15:8] * inten;
    pb = rgb_r[7:0] * inten;
  end

  always_ff @(posedge clk) begin
    if (load[ST_C]) begin
      hit_r   <= dpc.hit;
      red_r   <= pr[FRAC_BITS+7:FRAC_BITS];
      green_r <= pg[FRAC_BITS+7:FRAC_BITS];
      blue_r  <= pb[FRAC_BITS+7:FRAC_BITS];
    end
  end

  assign out_ch.hit   = hit_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  // ---------------- assertions ----------------
  a_miss_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |->
      (out_ch.red == 8'd0 && out_ch.green == 8'd0 && out_ch.blue == 8'd0))
    else $error("missed pixel carries color");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.red <= rgb_r[23:16] && out_ch.green <= rgb_r[15:8] &&
                      out_ch.blue <= rgb_r[7:0]))
    else $error("shaded channel above base color");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0 && !(in_ch.valid && in_ch.ready)) |=> !out_ch.valid)
    else $error("result without a transfer in flight");

endmodule
